[rtl/core/pdf_pkg.sv]
// ----------------------------------------------------------------------------
// pdf_pkg
// shared types, constants and the divisor table of the decimal formatter
// ----------------------------------------------------------------------------
package pdf_pkg;

	localparam int unsigned NUM_DIGITS = 5;
	localparam logic [2:0] MAX_WIDTH = 3'd5;
	localparam logic [2:0] LAST_POS = 3'd4;
	localparam logic [2:0] DONE_POS = 3'd5;

	localparam logic [7:0] CHAR_MINUS = 8'h2d;
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_SPACE = 8'h20;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_SIGN,
		ST_PAD,
		ST_DIGIT
	} state_t;

	typedef enum logic [1:0] {
		SEL_SIGN,
		SEL_PAD,
		SEL_DIGIT
	} char_sel_t;

	// control from the sequencer to the datapath
	typedef struct packed {
		logic load;
		logic step;
		logic emit;
		char_sel_t sel;
		logic last;
	} ctrl_t;

	// status from the datapath to the sequencer
	typedef struct packed {
		logic start;
		logic div_done;
		logic neg;
		logic pads_zero;
		logic pad_last;
		logic digit_last;
	} status_t;

	// power of ten for one digit position, most significant first
	function automatic logic [15:0] divisor(input logic [2:0] pos);
		logic [15:0] d;
		case (pos)
			3'd0: d = 16'd10000;
			3'd1: d = 16'd1000;
			3'd2: d = 16'd100;
			3'd3: d = 16'd10;
			3'd4: d = 16'd1;
			default: d = 16'd1;
		endcase
		return d;
	endfunction

endpackage

[rtl/core/pdf_sub_unit.sv]
// ----------------------------------------------------------------------------
// pdf_sub_unit
// shared compare and subtract against the power of ten of one digit position
// ----------------------------------------------------------------------------
module pdf_sub_unit (
	input  logic [15:0] x,
	input  logic [2:0]  pos,
	output logic        ge,
	output logic [15:0] diff
);
	import pdf_pkg::*;

	logic [16:0] sub;

	assign sub  = {1'b0, x} - {1'b0, divisor(pos)};
	assign ge   = ~sub[16];
	assign diff = sub[15:0];

endmodule

[rtl/core/pdf_ctrl.sv]
// ----------------------------------------------------------------------------
// pdf_ctrl
// sequencer: digit extraction, then sign, pad and digit emission
// ----------------------------------------------------------------------------
module pdf_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  pdf_pkg::status_t status,
	output pdf_pkg::ctrl_t   ctrl,
	output logic             busy
);
	import pdf_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (status.start) begin
					state_d = ST_DIVIDE;
				end
			end
			ST_DIVIDE: begin
				if (status.div_done) begin
					if (status.neg) begin
						state_d = ST_SIGN;
					end else if (!status.pads_zero) begin
						state_d = ST_PAD;
					end else begin
						state_d = ST_DIGIT;
					end
				end
			end
			ST_SIGN: begin
				state_d = status.pads_zero ? ST_DIGIT : ST_PAD;
			end
			ST_PAD: begin
				if (status.pad_last) begin
					state_d = ST_DIGIT;
				end
			end
			ST_DIGIT: begin
				if (status.digit_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl      = '0;
		ctrl.sel  = SEL_DIGIT;
		busy      = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy      = 1'b0;
				ctrl.load = status.start;
			end
			ST_DIVIDE: begin
				ctrl.step = ~status.div_done;
			end
			ST_SIGN: begin
				ctrl.emit = 1'b1;
				ctrl.sel  = SEL_SIGN;
			end
			ST_PAD: begin
				ctrl.emit = 1'b1;
				ctrl.sel  = SEL_PAD;
			end
			ST_DIGIT: begin
				ctrl.emit = 1'b1;
				ctrl.sel  = SEL_DIGIT;
				ctrl.last = status.digit_last;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule

[rtl/core/padded_decimal_formatter.sv]
// ----------------------------------------------------------------------------
// padded_decimal_formatter
// 16-bit value to padded ascii decimal text, one character per strobe
// ----------------------------------------------------------------------------
// channel   signals                                   transfer
// command   start, value, is_signed, pad_width,       start high, busy low
//           zero_pad, busy
// result    out_valid, out_char, last_char            every cycle out_valid high
//
// an item is loaded, then its digits are found by repeated subtraction in the
// shared subtract unit, one digit position after another, most significant
// first, then its characters (one to six) are emitted back to back
// busy stays high from the load until the final character is registered
// results cannot be stalled; each character is shown for one cycle only
// arst_n clears the sequencer and the result strobe
// ----------------------------------------------------------------------------
module padded_decimal_formatter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [15:0] value,
	input  logic        is_signed,
	input  logic [2:0]  pad_width,
	input  logic        zero_pad,
	output logic        out_valid,
	output logic [7:0]  out_char,
	output logic        last_char
);
	import pdf_pkg::*;

	ctrl_t   ctrl;
	status_t status;

	// working magnitude and per-item settings
	logic [15:0] x_q;
	logic        neg_q;
	logic [2:0]  width_q;
	logic        zpad_q;

	// digit extraction
	logic [2:0]  pos_q;
	logic [3:0]  cnt_q;
	logic        started_q;
	logic [2:0]  first_q;
	logic [3:0]  dig_q [NUM_DIGITS];

	// emission counters
	logic [2:0]  pc_q;
	logic [2:0]  dp_q;

	// result register
	logic        out_valid_q;
	logic [7:0]  out_char_q;
	logic        last_q;

	logic        ge;
	logic [15:0] diff;
	logic [2:0]  nd;
	logic [2:0]  pads;
	logic        neg_in;
	logic [15:0] mag_in;
	logic [7:0]  char_d;

	pdf_sub_unit u_sub (
		.x    (x_q),
		.pos  (pos_q),
		.ge   (ge),
		.diff (diff)
	);

	pdf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl),
		.busy   (busy)
	);

	// magnitude of the input, modulo 2^16 so the most negative value stays exact
	assign neg_in = is_signed & value[15];
	assign mag_in = neg_in ? (~value + 16'd1) : value;

	// significant digit count and pad characters still owed
	assign nd   = DONE_POS - first_q;
	assign pads = (width_q > nd) ? (width_q - nd) : 3'd0;

	assign status.start      = start;
	assign status.div_done   = (pos_q == DONE_POS);
	assign status.neg        = neg_q;
	assign status.pads_zero  = (pads == 3'd0);
	assign status.pad_last   = ((pc_q + 3'd1) == pads);
	assign status.digit_last = (dp_q == LAST_POS);

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			x_q       <= mag_in;
			neg_q     <= neg_in;
			width_q   <= (pad_width > MAX_WIDTH) ? MAX_WIDTH : pad_width;
			zpad_q    <= zero_pad;
			pos_q     <= 3'd0;
			cnt_q     <= 4'd0;
			started_q <= 1'b0;
			first_q   <= LAST_POS;
		end else if (ctrl.step) begin
			if (ge) begin
				// one more multiple of this power of ten
				x_q   <= diff;
				cnt_q <= cnt_q + 4'd1;
			end else begin
				// digit finished: store it and note the first nonzero position
				dig_q[pos_q] <= cnt_q;
				if ((cnt_q != 4'd0) && !started_q) begin
					first_q   <= pos_q;
					started_q <= 1'b1;
				end
				pos_q <= pos_q + 3'd1;
				cnt_q <= 4'd0;
			end
		end
	end

	// pad counter and digit pointer
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			pc_q <= 3'd0;
		end else if (ctrl.emit && (ctrl.sel == SEL_PAD)) begin
			pc_q <= pc_q + 3'd1;
		end
		if (ctrl.emit && (ctrl.sel == SEL_DIGIT)) begin
			dp_q <= dp_q + 3'd1;
		end else begin
			dp_q <= first_q;
		end
	end

	// character selection
	always_comb begin
		case (ctrl.sel)
			SEL_SIGN:  char_d = CHAR_MINUS;
			SEL_PAD:   char_d = zpad_q ? CHAR_ZERO : CHAR_SPACE;
			SEL_DIGIT: char_d = CHAR_ZERO | {4'd0, dig_q[dp_q]};
			default:   char_d = CHAR_ZERO;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= ctrl.emit;
		end
	end

	always_ff @(posedge clk) begin
		out_char_q <= char_d;
		last_q     <= ctrl.last;
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign last_char = last_q;

endmodule
